[rtl/core/tltd_pkg.sv]
// Shared types and constants for the tile layer text decoder.
package tltd_pkg;

    localparam logic [1:0] MODE_WS  = 2'd0;
    localparam logic [1:0] MODE_CSV = 2'd1;
    localparam logic [1:0] MODE_B64 = 2'd2;
    localparam logic [1:0] MODE_RESET = MODE_CSV;

    localparam logic [31:0] TILE_MASK = 32'h1FFF_FFFF;
    localparam logic [35:0] LIMIT_MAG = 36'h0_8000_0000;

    localparam logic [3:0] DIGIT_BITS = 4'd6;
    localparam logic [3:0] BYTE_BITS  = 4'd8;

    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_COMMA = 8'd44;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_SLASH = 8'd47;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_UP_A  = 8'd65;
    localparam logic [7:0] CHAR_UP_Z  = 8'd90;
    localparam logic [7:0] CHAR_LO_A  = 8'd97;
    localparam logic [7:0] CHAR_LO_Z  = 8'd122;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_DONE   = 3'd3,
        PH_FAIL   = 3'd4
    } phase_t;

    typedef struct packed {
        logic       end_mark;
        logic       is_ws;
        logic       is_blank;
        logic       is_comma;
        logic       is_digit;
        logic       is_sign;
        logic       is_minus;
        logic       b64_ok;
        logic [3:0] digit;
        logic [5:0] b64_val;
    } char_class_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[rtl/core/tltd_channels.sv]
// Channel interfaces for text requests, tile results and mode writes.
interface tltd_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface tltd_tile_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] tile_id;
    logic               tile_valid;
    logic               last;
    logic               layer_empty;

    modport source (output valid, output tile_id, output tile_valid, output last,
                    output layer_empty, input ready);
    modport sink (input valid, input tile_id, input tile_valid, input last,
                  input layer_empty, output ready);
endinterface

interface tltd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/tltd_front.sv]
// Front end: accepts text requests and classifies each character.
module tltd_front (
    tltd_text_if.sink              text,
    input  tltd_pkg::queue_status_t status,
    output logic                   push,
    output tltd_pkg::char_class_t  push_data
);

    logic [7:0] c;

    assign c          = text.char_code;
    assign text.ready = !status.full;
    assign push       = text.valid;

    always_comb
    begin
        push_data          = '0;
        push_data.end_mark = text.end_of_text;
        push_data.is_ws    = (c == tltd_pkg::CHAR_SPACE) ||
                             (c >= tltd_pkg::CHAR_TAB && c <= tltd_pkg::CHAR_CR);
        push_data.is_blank = (c == tltd_pkg::CHAR_SPACE) || (c == tltd_pkg::CHAR_LF) ||
                             (c == tltd_pkg::CHAR_CR);
        push_data.is_comma = (c == tltd_pkg::CHAR_COMMA);
        push_data.is_digit = (c >= tltd_pkg::CHAR_ZERO) && (c <= tltd_pkg::CHAR_NINE);
        push_data.is_sign  = (c == tltd_pkg::CHAR_PLUS) || (c == tltd_pkg::CHAR_MINUS);
        push_data.is_minus = (c == tltd_pkg::CHAR_MINUS);
        push_data.digit    = 4'(c - tltd_pkg::CHAR_ZERO);
        if (c >= tltd_pkg::CHAR_UP_A && c <= tltd_pkg::CHAR_UP_Z)
        begin
            push_data.b64_ok  = 1'b1;
            push_data.b64_val = 6'(c - tltd_pkg::CHAR_UP_A);
        end
        else if (c >= tltd_pkg::CHAR_LO_A && c <= tltd_pkg::CHAR_LO_Z)
        begin
            push_data.b64_ok  = 1'b1;
            push_data.b64_val = 6'(c - tltd_pkg::CHAR_LO_A + 8'd26);
        end
        else if (c >= tltd_pkg::CHAR_ZERO && c <= tltd_pkg::CHAR_NINE)
        begin
            push_data.b64_ok  = 1'b1;
            push_data.b64_val = 6'(c - tltd_pkg::CHAR_ZERO + 8'd52);
        end
        else if (c == tltd_pkg::CHAR_PLUS)
        begin
            push_data.b64_ok  = 1'b1;
            push_data.b64_val = 6'd62;
        end
        else if (c == tltd_pkg::CHAR_SLASH)
        begin
            push_data.b64_ok  = 1'b1;
            push_data.b64_val = 6'd63;
        end
    end

endmodule

[rtl/core/tltd_queue.sv]
// Short queue of classified characters between the front and back ends.
module tltd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tltd_pkg::char_class_t   push_data,
    input  logic                    pop,
    output tltd_pkg::char_class_t   head,
    output tltd_pkg::queue_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    tltd_pkg::char_class_t entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/tltd_back.sv]
// Back end: number and base64 decoding state and the output register.
module tltd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_data,
    input  tltd_pkg::char_class_t item,
    input  logic                  item_avail,
    output logic                  pop,
    tltd_tile_if.source           tiles
);

    logic [1:0]         mode_reg;
    logic [13:0]        acc_reg, acc_next;
    logic [3:0]         pend_reg, pend_next;
    logic [23:0]        word_reg, word_next;
    logic [1:0]         bpos_reg, bpos_next;
    logic [31:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    tltd_pkg::phase_t   phase_reg, phase_next;
    logic               ovf_reg, ovf_next;
    logic               cell_reg, cell_next;
    logic               any_reg, any_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_id_reg, out_id_next;
    logic               out_tv_reg, out_tv_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;

    logic               num_ok;
    logic [31:0]        num_val;
    logic               take;
    logic [35:0]        prod;
    logic               emit;
    logic [31:0]        emit_id;
    logic               emit_tv;
    logic               have;
    logic [13:0]        acc_sh;
    logic [3:0]         pend_sum;
    logic [3:0]         pend_left;
    logic [7:0]         byte_val;

    assign pop               = item_avail && (!out_valid_reg || tiles.ready);
    assign tiles.valid       = out_valid_reg;
    assign tiles.tile_id     = out_id_reg;
    assign tiles.tile_valid  = out_tv_reg;
    assign tiles.last        = out_last_reg;
    assign tiles.layer_empty = out_empty_reg;

    assign num_ok  = ((phase_reg == tltd_pkg::PH_DIGITS) || (phase_reg == tltd_pkg::PH_DONE)) &&
                     !ovf_reg && (neg_reg || !mag_reg[31]);
    assign num_val = neg_reg ? (32'd0 - mag_reg) : mag_reg;
    assign prod    = {4'd0, mag_reg} * 36'd10 + {32'd0, item.digit};

    assign acc_sh    = {acc_reg[7:0], item.b64_val};
    assign pend_sum  = pend_reg + tltd_pkg::DIGIT_BITS;
    assign pend_left = pend_sum - tltd_pkg::BYTE_BITS;
    assign byte_val  = 8'(acc_sh >> pend_left);

    always_comb
    begin
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        word_next  = word_reg;
        bpos_next  = bpos_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        phase_next = phase_reg;
        ovf_next   = ovf_reg;
        cell_next  = cell_reg;
        any_next   = any_reg;
        take       = 1'b0;
        emit       = 1'b0;
        emit_id    = '0;
        emit_tv    = 1'b0;
        have       = 1'b0;

        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_tv_next    = out_tv_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;

        if (cfg_we)
        begin
            acc_next   = '0;
            pend_next  = '0;
            word_next  = '0;
            bpos_next  = '0;
            mag_next   = '0;
            neg_next   = 1'b0;
            phase_next = tltd_pkg::PH_LEAD;
            ovf_next   = 1'b0;
            cell_next  = 1'b0;
            any_next   = 1'b0;
        end
        else if (pop)
        begin
            if (item.end_mark)
            begin
                if (mode_reg == tltd_pkg::MODE_CSV)
                begin
                    have    = cell_reg;
                    emit_id = num_ok ? num_val : '0;
                end
                else if (mode_reg == tltd_pkg::MODE_WS)
                begin
                    have    = cell_reg && num_ok;
                    emit_id = have ? num_val : '0;
                end
                emit     = 1'b1;
                emit_tv  = have;
                acc_next   = '0;
                pend_next  = '0;
                word_next  = '0;
                bpos_next  = '0;
                mag_next   = '0;
                neg_next   = 1'b0;
                phase_next = tltd_pkg::PH_LEAD;
                ovf_next   = 1'b0;
                cell_next  = 1'b0;
                any_next   = 1'b0;
            end
            else
            begin
                case (mode_reg)
                    tltd_pkg::MODE_CSV, tltd_pkg::MODE_WS:
                    begin
                        if ((mode_reg == tltd_pkg::MODE_CSV && item.is_comma) ||
                            (mode_reg == tltd_pkg::MODE_WS && item.is_ws))
                        begin
                            if (mode_reg == tltd_pkg::MODE_CSV)
                            begin
                                emit    = cell_reg;
                                emit_id = num_ok ? num_val : '0;
                            end
                            else
                            begin
                                emit    = cell_reg && num_ok;
                                emit_id = num_val;
                            end
                            emit_tv    = 1'b1;
                            mag_next   = '0;
                            neg_next   = 1'b0;
                            phase_next = tltd_pkg::PH_LEAD;
                            ovf_next   = 1'b0;
                            cell_next  = 1'b0;
                            if (emit)
                            begin
                                any_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (mode_reg == tltd_pkg::MODE_WS || !item.is_blank)
                            begin
                                cell_next = 1'b1;
                            end
                            case (phase_reg)
                                tltd_pkg::PH_LEAD:
                                begin
                                    if (item.is_ws)
                                    begin
                                        phase_next = tltd_pkg::PH_LEAD;
                                    end
                                    else if (item.is_sign)
                                    begin
                                        neg_next   = item.is_minus;
                                        phase_next = tltd_pkg::PH_SIGN;
                                    end
                                    else if (!item.is_digit)
                                    begin
                                        phase_next = tltd_pkg::PH_FAIL;
                                    end
                                    else
                                    begin
                                        phase_next = tltd_pkg::PH_DIGITS;
                                        take       = 1'b1;
                                    end
                                end
                                tltd_pkg::PH_SIGN:
                                begin
                                    if (!item.is_digit)
                                    begin
                                        phase_next = tltd_pkg::PH_FAIL;
                                    end
                                    else
                                    begin
                                        phase_next = tltd_pkg::PH_DIGITS;
                                        take       = 1'b1;
                                    end
                                end
                                tltd_pkg::PH_DIGITS:
                                begin
                                    if (!item.is_digit)
                                    begin
                                        phase_next = tltd_pkg::PH_DONE;
                                    end
                                    else
                                    begin
                                        take = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    phase_next = phase_reg;
                                end
                            endcase
                            if (take && !ovf_reg)
                            begin
                                if (prod > tltd_pkg::LIMIT_MAG)
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    mag_next = prod[31:0];
                                end
                            end
                        end
                    end
                    tltd_pkg::MODE_B64:
                    begin
                        if (item.b64_ok)
                        begin
                            if (pend_sum < tltd_pkg::BYTE_BITS)
                            begin
                                acc_next  = acc_sh;
                                pend_next = pend_sum;
                            end
                            else
                            begin
                                pend_next = pend_left;
                                acc_next  = acc_sh & 14'((14'd1 << pend_left) - 14'd1);
                                if (bpos_reg != 2'd3)
                                begin
                                    word_next = word_reg | 24'({16'd0, byte_val}
                                                               << {bpos_reg, 3'b000});
                                    bpos_next = bpos_reg + 2'd1;
                                end
                                else
                                begin
                                    emit      = 1'b1;
                                    emit_tv   = 1'b1;
                                    emit_id   = {byte_val, word_reg} & tltd_pkg::TILE_MASK;
                                    word_next = '0;
                                    bpos_next = '0;
                                    any_next  = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end

        if (pop && emit)
        begin
            out_valid_next = 1'b1;
            out_id_next    = emit_id;
            out_tv_next    = emit_tv;
            out_last_next  = item.end_mark;
            out_empty_next = item.end_mark && !(any_reg || have);
        end
        else if (tiles.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= tltd_pkg::MODE_RESET;
            acc_reg       <= '0;
            pend_reg      <= '0;
            word_reg      <= '0;
            bpos_reg      <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            phase_reg     <= tltd_pkg::PH_LEAD;
            ovf_reg       <= 1'b0;
            cell_reg      <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            word_reg      <= word_next;
            bpos_reg      <= bpos_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            phase_reg     <= phase_next;
            ovf_reg       <= ovf_next;
            cell_reg      <= cell_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_id_reg    <= out_id_next;
        out_tv_reg    <= out_tv_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

endmodule

[rtl/core/tile_layer_text_decoder_core.sv]
// Top level of the tile layer text decoder: front end, queue and back end.
//
//   Channel | Direction | Carries
//   text    | in        | char_code, end_of_text
//   tiles   | out       | tile_id, tile_valid, last, layer_empty
//   cfg     | in        | data (encoding mode)
//
// One request is taken per cycle unless the queue is full; its result is registered.
// The back end retires one queued character per cycle, bounded by its output register.
// Reset clears all layer state and sets the mode to comma-separated decimals.
// A stalled result holds the back end, and the queue absorbs requests until it fills.
module tile_layer_text_decoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    tltd_text_if.sink  text,
    tltd_tile_if.source tiles,
    tltd_cfg_if.sink   cfg
);

    tltd_pkg::char_class_t   push_data;
    tltd_pkg::char_class_t   head;
    tltd_pkg::queue_status_t q_status;
    logic                    push;
    logic                    pop;
    logic                    cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    tltd_front u_front (
        .text      (text),
        .status    (q_status),
        .push      (push),
        .push_data (push_data)
    );

    tltd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    tltd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg.data),
        .item       (head),
        .item_avail (!q_status.empty),
        .pop        (pop),
        .tiles      (tiles)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("Queue reports full and empty at once.");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> text.ready)
        else $error("Front end stalls requests while the queue is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tiles.valid && tiles.tile_valid) |-> !tiles.layer_empty)
        else $error("Result carries a tile but flags an empty layer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tiles.valid && !tiles.tile_valid) |-> (tiles.last && tiles.tile_id == 32'sd0))
        else $error("Result without a tile is not a clean end marker.");

endmodule
